// File: hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned CfgW       = 8;
    localparam int unsigned ApbDataW   = 32;
    localparam int unsigned ApbAddrW   = 3;
    localparam int unsigned InDataW    = 16;
    localparam int unsigned InUserW    = 3;
    localparam int unsigned OutDataW   = 16;

    localparam logic [CfgW-1:0] HalfPeriodRst = 8'd2;
    localparam logic [CfgW-1:0] AckTimeoutRst = 8'd250;

    localparam logic [3:0] BitsPerByte = 4'd8;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_WAIT  = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_STOP_A   = 4'd3,
        PH_STOP_B   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_WR_LOW   = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_HIGH  = 4'd8,
        PH_ACK_LOW  = 4'd9,
        PH_ACK_HIGH = 4'd10,
        PH_WA_A     = 4'd11,
        PH_WA_B     = 4'd12,
        PH_WA_POLL  = 4'd13
    } t_phase;

    typedef enum logic [0:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_ACK_TIMEOUT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CfgW-1:0] half_period_ticks;
        logic [CfgW-1:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        t_op        operation;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_sample;
    } t_request;

    typedef struct packed {
        logic       command_rejected;
        logic       ack_failed;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_enable;
        logic       sda_level;
        logic       scl_level;
    } t_result;

endpackage

// File: hw/rtl/i2cm_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_cfg_regs
// APB register file: bus delay step length and acknowledge timeout.
// ---------------------------------------------------------------------------
module i2cm_cfg_regs
    import i2cm_pkg::*;
#(
    parameter logic [CfgW-1:0] HALF_PERIOD_RST = HalfPeriodRst,
    parameter logic [CfgW-1:0] ACK_TIMEOUT_RST = AckTimeoutRst
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    logic [CfgW-1:0] r_half_period;
    logic [CfgW-1:0] r_ack_timeout;
    logic            w_wr;
    t_reg_idx        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    // word aligned: byte offset bits are ignored
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HALF_PERIOD: r_half_period <= pwdata[CfgW-1:0];
                REG_ACK_TIMEOUT: r_ack_timeout <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_HALF_PERIOD: prdata[CfgW-1:0] = r_half_period;
            REG_ACK_TIMEOUT: prdata[CfgW-1:0] = r_ack_timeout;
            default: ;
        endcase
    end

    assign o_cfg.half_period_ticks = r_half_period;
    assign o_cfg.ack_timeout       = r_ack_timeout;

endmodule

// File: hw/rtl/i2cm_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_engine
// Pin sequencer: phase state machine, shift register and delay counters.
// ---------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_request i_req,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    t_phase     r_phase,   n_phase;
    logic [3:0] r_bits,    n_bits;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_delay,   n_delay;
    logic [7:0] r_tmo,     n_tmo;
    logic       r_ack_sel, n_ack_sel;
    logic       r_scl,     n_scl;
    logic       r_sda,     n_sda;
    logic       r_sda_en,  n_sda_en;
    logic       r_fail,    n_fail;
    logic [7:0] r_rx,      n_rx;

    logic       w_is_cmd;
    logic       w_tick;
    logic       w_cmd;
    logic       w_rej;
    logic       w_step;
    logic       w_poll;
    logic       w_fail;
    logic       w_load;
    logic       w_done;
    logic [7:0] w_hp;
    logic [7:0] w_tmo;
    logic [3:0] w_bits_inc;

    assign w_is_cmd = (i_req.operation == OP_START) || (i_req.operation == OP_STOP)
                   || (i_req.operation == OP_WRITE) || (i_req.operation == OP_READ)
                   || (i_req.operation == OP_WAIT);
    assign w_tick   = i_fire && (i_req.operation == OP_TICK) && (r_phase != PH_IDLE);
    assign w_cmd    = i_fire && w_is_cmd && (r_phase == PH_IDLE);
    assign w_rej    = i_fire && w_is_cmd && (r_phase != PH_IDLE);
    // a pin step falls on the tick that ends the bus delay
    assign w_step   = w_tick && (r_phase != PH_WA_POLL) && (r_delay <= 8'd1);
    assign w_poll   = (w_tick && (r_phase == PH_WA_POLL))
                   || (w_step && (r_phase == PH_WA_B));
    // the first poll starts from a cleared timeout count
    assign w_tmo    = (r_phase == PH_WA_B) ? 8'd0 : r_tmo;
    assign w_fail   = w_poll && i_req.sda_sample && (w_tmo >= i_cfg.ack_timeout);
    assign w_hp     = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign w_bits_inc = r_bits + 4'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        w_done  = 1'b0;
        if (w_cmd) begin
            unique case (i_req.operation)
                OP_START: n_phase = PH_START_A;
                OP_STOP:  n_phase = PH_STOP_A;
                OP_WRITE: n_phase = PH_WR_HIGH;
                OP_READ:  n_phase = PH_RD_LOW;
                default:  n_phase = PH_WA_A;
            endcase
        end else if (w_poll) begin
            if (!i_req.sda_sample) begin
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end else if (w_fail) begin
                n_phase = PH_STOP_A;
            end else begin
                n_phase = PH_WA_POLL;
            end
        end else if (w_step) begin
            unique case (r_phase)
                PH_START_A: n_phase = PH_START_B;
                PH_START_B: begin
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
                PH_STOP_A:  n_phase = PH_STOP_B;
                PH_STOP_B: begin
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
                PH_WR_HIGH: n_phase = PH_WR_LOW;
                PH_WR_LOW: begin
                    if (w_bits_inc >= BitsPerByte) begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end else begin
                        n_phase = PH_WR_HIGH;
                    end
                end
                PH_RD_LOW:  n_phase = PH_RD_HIGH;
                PH_RD_HIGH: n_phase = (w_bits_inc < BitsPerByte) ? PH_RD_LOW : PH_ACK_LOW;
                PH_ACK_LOW: n_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: begin
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
                PH_WA_A:    n_phase = PH_WA_B;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    // every move into a timed phase restarts the bus delay
    assign w_load = (w_cmd || w_poll || w_step)
                 && (n_phase != PH_IDLE) && (n_phase != PH_WA_POLL);

    // pins, shifter and counters
    always_comb begin
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_tmo     = r_tmo;
        n_ack_sel = r_ack_sel;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_en  = r_sda_en;
        n_fail    = r_fail;
        n_rx      = r_rx;

        if (w_load) begin
            n_delay = w_hp;
        end else if (w_tick && (r_phase != PH_WA_POLL) && (r_delay > 8'd1)) begin
            n_delay = r_delay - 8'd1;
        end else begin
            n_delay = r_delay;
        end

        if (w_cmd) begin
            n_fail = 1'b0;
            n_bits = 4'd0;
            unique case (i_req.operation)
                OP_START: begin
                    n_sda_en = 1'b1;
                    n_sda    = 1'b1;
                    n_scl    = 1'b1;
                end
                OP_STOP: begin
                    n_sda_en = 1'b1;
                    n_scl    = 1'b0;
                    n_sda    = 1'b0;
                end
                OP_WRITE: begin
                    n_sda_en = 1'b1;
                    n_sda    = i_req.write_data[7];
                    n_shift  = {i_req.write_data[6:0], 1'b0};
                    n_scl    = 1'b1;
                end
                OP_READ: begin
                    n_sda_en  = 1'b0;
                    n_ack_sel = i_req.send_ack;
                    n_shift   = 8'd0;
                    n_scl     = 1'b0;
                end
                default: begin
                    n_sda_en = 1'b0;
                    n_sda    = 1'b1;
                    n_tmo    = 8'd0;
                end
            endcase
        end else if (w_poll) begin
            n_tmo = w_tmo;
            if (!i_req.sda_sample) begin
                n_scl = 1'b0;
            end else if (w_fail) begin
                // timed out: flag it and run a stop
                n_fail   = 1'b1;
                n_sda_en = 1'b1;
                n_scl    = 1'b0;
                n_sda    = 1'b0;
            end else begin
                n_tmo = w_tmo + 8'd1;
            end
        end else if (w_step) begin
            unique case (r_phase)
                PH_START_A: n_sda = 1'b0;
                PH_START_B: n_scl = 1'b0;
                PH_STOP_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                PH_WR_HIGH: n_scl = 1'b0;
                PH_WR_LOW: begin
                    n_bits = w_bits_inc;
                    if (w_bits_inc < BitsPerByte) begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                    end
                end
                PH_RD_LOW: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_req.sda_sample};
                end
                PH_RD_HIGH: begin
                    n_bits = w_bits_inc;
                    n_scl  = 1'b0;
                    if (w_bits_inc >= BitsPerByte) begin
                        n_sda_en = 1'b1;
                        n_sda    = ~r_ack_sel;
                    end
                end
                PH_ACK_LOW: n_scl = 1'b1;
                PH_ACK_HIGH: begin
                    n_scl = 1'b0;
                    n_rx  = r_shift;
                end
                PH_WA_A:    n_scl = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bits    <= 4'd0;
            r_shift   <= 8'd0;
            r_delay   <= 8'd0;
            r_tmo     <= 8'd0;
            r_ack_sel <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_sda_en  <= 1'b1;
            r_fail    <= 1'b0;
            r_rx      <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_bits    <= n_bits;
            r_shift   <= n_shift;
            r_delay   <= n_delay;
            r_tmo     <= n_tmo;
            r_ack_sel <= n_ack_sel;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_sda_en  <= n_sda_en;
            r_fail    <= n_fail;
            r_rx      <= n_rx;
        end
    end

    assign o_result.scl_level        = n_scl;
    assign o_result.sda_level        = n_sda;
    assign o_result.sda_drive_enable = n_sda_en;
    assign o_result.busy_res         = (n_phase != PH_IDLE);
    assign o_result.done_res         = w_done;
    assign o_result.read_data        = n_rx;
    assign o_result.ack_failed       = n_fail;
    assign o_result.command_rejected = w_rej;

endmodule

// File: hw/rtl/i2cm_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_out_stage
// Result register with valid flag; takes a new result while the old one
// drains.
// ---------------------------------------------------------------------------
module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hw/rtl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master pin sequencer driven by command and tick requests.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per beat. tuser carries the operation (tick,
//   start, stop, write, read, wait ack); tdata carries the write byte, the
//   ACK/NACK choice for reads and the sampled SDA level for ticks.
//   Master stream: exactly one result per request, in order: SCL/SDA levels,
//   SDA drive enable, busy, done, last read byte, ack failure, rejection.
//   APB: half_period_ticks at 0x0, ack_timeout at 0x4; write only while idle.
// Timing:
//   A result is registered and appears in the cycle after its request is
//   taken. One request per cycle is sustained unless tready is held low;
//   the result register decouples the two streams.
// Reset: bus lines idle high with SDA driven, no result pending, registers
//   back to 2 and 250.
// Stall: while the receiver holds tready low the result stays put; one more
//   request is taken only when the result register empties in that cycle.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter logic [CfgW-1:0] HALF_PERIOD_RST = HalfPeriodRst,
    parameter logic [CfgW-1:0] ACK_TIMEOUT_RST = AckTimeoutRst
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [7:0] write_data, [8] send_ack, [9] sda_sample, [15:10] zero
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    // [2:0] operation
    input  logic [InUserW-1:0]  i_s_axis_tuser,
    // master stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [3] busy_res,
    // [4] done_res, [12:5] read_data, [13] ack_failed, [14] command_rejected,
    // [15] zero
    output logic [OutDataW-1:0] o_m_axis_tdata,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    t_cfg     w_cfg;
    t_request w_req;
    t_result  w_result;
    t_result  w_out;
    logic     w_fire;
    logic     w_space;

    assign w_req.operation  = t_op'(i_s_axis_tuser);
    assign w_req.write_data = i_s_axis_tdata[7:0];
    assign w_req.send_ack   = i_s_axis_tdata[8];
    assign w_req.sda_sample = i_s_axis_tdata[9];

    assign o_s_axis_tready = w_space;
    assign w_fire          = i_s_axis_tvalid & w_space;

    i2cm_cfg_regs #(
        .HALF_PERIOD_RST (HALF_PERIOD_RST),
        .ACK_TIMEOUT_RST (ACK_TIMEOUT_RST)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    i2cm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_req    (w_req),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    i2cm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_space  (w_space),
        .o_valid  (o_m_axis_tvalid),
        .o_result (w_out)
    );

    assign o_m_axis_tdata = {1'b0, w_out};

endmodule

// File: hw/rtl/i2cm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master bit engine, bound to the top level.
// ---------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OutDataW-1:0] o_m_axis_tdata
);

    // a finished sequence leaves the engine idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[4] |-> !o_m_axis_tdata[3])
        else $error("done reported while still busy");

    // a request is only turned away while a sequence runs
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[14] |-> o_m_axis_tdata[3])
        else $error("request rejected while idle");

    // a timed-out acknowledge keeps SDA driven for the stop
    a_fail_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[13] |-> o_m_axis_tdata[2])
        else $error("ack failure with SDA released");

    // an empty result register never blocks the request side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request stalled with no pending result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("pending result changed under stall");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
